>>> hw/rtl/text_console_writer_assert.svh
// Assertion macros for the text console writer RTL.
// Uses clk and rst_n of the including module; empty bodies under SYNTHESIS.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH
`ifndef SYNTHESIS
`define TCW_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);
`define TCW_CHECK_NEXT(lbl, ante, cons, msg) \
  `TCW_CHECK(lbl, (ante) |=> (cons), msg)
`else
`define TCW_CHECK(lbl, prop, msg)
`define TCW_CHECK_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
// No dependencies.
package tcw_pkg;

  localparam int DEF_COLUMNS   = 80;
  localparam int DEF_ROWS      = 25;
  localparam int DEF_TAB_WIDTH = 8;

  localparam int KIND_W    = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int COL_OUT_W = 7;
  localparam int ROW_OUT_W = 5;
  localparam int LOC_OUT_W = 11;
  localparam int CELL_W    = 16;
  localparam int ATTR_W    = 8;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CH_BS      = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE = 2'd0,
    KIND_CLEAR = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CLEAR,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic apply;
    logic home;
  } cur_ctrl_t;

  typedef struct packed {
    logic print;
    logic scroll;
  } cur_stat_t;

endpackage

>>> hw/rtl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/tcw_cursor.sv
// Cursor column, row and linear location, with the character update rules.
// Depends on tcw_pkg and text_console_writer_assert.svh.
`include "text_console_writer_assert.svh"
module tcw_cursor #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tcw_pkg::cur_ctrl_t               ctrl,
  input  logic [tcw_pkg::CHAR_W-1:0]       ch,
  output tcw_pkg::cur_stat_t               stat,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  loc_r,
  output logic [$clog2(COLUMNS)-1:0]       col_nxt,
  output logic [$clog2(ROWS)-1:0]          row_nxt,
  output logic [$clog2(COLUMNS*ROWS)-1:0]  loc_nxt
);
  import tcw_pkg::*;

  localparam int COL_W = $clog2(COLUMNS);
  localparam int ROW_W = $clog2(ROWS);
  localparam int LOC_W = $clog2(COLUMNS * ROWS);
  localparam int CW    = COL_W + 2;
  localparam int MAXK  = (COLUMNS - 1) / TAB_WIDTH + 1;

  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_x;
  logic [CW-1:0]    tab_col;
  logic [CW-1:0]    step_col;
  logic [CW-1:0]    col_fin;
  logic             row_inc;
  logic             print;
  logic             last_row;
  logic             row_adv;
  logic [LOC_W-1:0] row_base;
  logic [LOC_W-1:0] loc_calc;

  assign col_x = {2'b00, col_r};

  always_comb begin
    tab_col = CW'(MAXK * TAB_WIDTH);
    for (int k = MAXK; k >= 1; k--) begin
      if (CW'(k * TAB_WIDTH) > col_x) begin
        tab_col = CW'(k * TAB_WIDTH);
      end
    end
  end

  always_comb begin
    step_col = col_x;
    row_inc  = 1'b0;
    print    = 1'b0;
    priority if (ch == CH_BS) begin
      if (col_r != '0) begin
        step_col = col_x - CW'(1);
      end
    end else if (ch == CH_TAB) begin
      step_col = tab_col;
    end else if (ch == CH_CR) begin
      step_col = '0;
    end else if (ch == CH_LF) begin
      step_col = '0;
      row_inc  = 1'b1;
    end else if (!ch[CHAR_W-1] && ch >= BLANK_CHAR) begin
      print    = 1'b1;
      step_col = col_x + CW'(1);
    end else begin
      step_col = col_x;
    end
    col_fin = step_col;
    if (step_col >= CW'(COLUMNS)) begin
      col_fin = '0;
      row_inc = 1'b1;
    end
  end

  assign last_row = (row_r == ROW_W'(ROWS - 1));
  assign row_adv  = row_inc & ~last_row;
  assign row_base = loc_r - LOC_W'(col_r);
  assign loc_calc = row_base + (row_adv ? LOC_W'(COLUMNS) : '0) + LOC_W'(col_fin);

  assign stat.print  = print;
  assign stat.scroll = row_inc & last_row;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    loc_nxt = loc_r;
    priority if (ctrl.home) begin
      col_nxt = '0;
      row_nxt = '0;
      loc_nxt = '0;
    end else if (ctrl.apply) begin
      col_nxt = col_fin[COL_W-1:0];
      row_nxt = row_adv ? row_r + ROW_W'(1) : row_r;
      loc_nxt = loc_calc;
    end else begin
      col_nxt = col_r;
      row_nxt = row_r;
      loc_nxt = loc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      loc_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      loc_r <= loc_nxt;
    end
  end

  `TCW_CHECK(a_loc_matches, int'(loc_r) == int'(row_r) * COLUMNS + int'(col_r), "bad location")
  `TCW_CHECK(a_col_range, int'(col_r) < COLUMNS && int'(row_r) < ROWS, "cursor out of range")

endmodule

>>> hw/rtl/text_console_writer.sv
// Text console writer top level: control sequencer, cell RAM, output register.
// Depends on tcw_pkg, tcw_ram, tcw_cursor and text_console_writer_assert.svh.
// An accepted item runs in ST_EXEC and its result goes to the output register;
// in_stall holds off new items until it is loaded. A scroll moves rows up and
// blanks the last row, a clear blanks all cells, one cell write per cycle through
// the single RAM write port. After reset, zeroing all cells holds in_stall high.
`include "text_console_writer_assert.svh"
module text_console_writer #(
  parameter int COLUMNS   = tcw_pkg::DEF_COLUMNS,
  parameter int ROWS      = tcw_pkg::DEF_ROWS,
  parameter int TAB_WIDTH = tcw_pkg::DEF_TAB_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [tcw_pkg::ATTR_W-1:0]    cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [tcw_pkg::KIND_W-1:0]    in_kind,
  input  logic [tcw_pkg::CHAR_W-1:0]    in_character,
  input  logic [tcw_pkg::IDX_W-1:0]     in_cell_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcw_pkg::COL_OUT_W-1:0] out_cursor_col,
  output logic [tcw_pkg::ROW_OUT_W-1:0] out_cursor_row,
  output logic [tcw_pkg::LOC_OUT_W-1:0] out_cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]    out_cell_data
);
  import tcw_pkg::*;

  localparam int CELLS    = COLUMNS * ROWS;
  localparam int COPY_LEN = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W   = $clog2(CELLS);
  localparam int CNT_W    = $clog2(CELLS + 1);
  localparam int COL_W    = $clog2(COLUMNS);
  localparam int ROW_W    = $clog2(ROWS);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                pend_r, pend_nxt;
  logic [ADDR_W-1:0]   paddr_r, paddr_nxt;
  logic                pcopy_r, pcopy_nxt;
  logic [CELL_W-1:0]   data_r, data_nxt;
  logic [ATTR_W-1:0]   attr_r;
  kind_t               kind_r;
  logic [CHAR_W-1:0]   ch_r;
  logic                inrange_r;
  logic                out_valid_r;
  logic [COL_OUT_W-1:0] out_col_r;
  logic [ROW_OUT_W-1:0] out_row_r;
  logic [LOC_OUT_W-1:0] out_loc_r;
  logic [CELL_W-1:0]   out_data_r;

  logic                in_acc;
  logic                out_free;
  logic                out_load;
  logic [CELL_W-1:0]   blank;
  logic [ADDR_W+IDX_W-1:0] idx_ext;
  logic                idx_ok;
  logic [CNT_W:0]      src_sum;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [CELL_W-1:0]   ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [CELL_W-1:0]   ram_rdata;

  cur_ctrl_t           cur_ctrl;
  cur_stat_t           cur_stat;
  logic [ADDR_W-1:0]   cur_loc;
  logic [COL_W-1:0]    cur_col_nxt;
  logic [ROW_W-1:0]    cur_row_nxt;
  logic [ADDR_W-1:0]   cur_loc_nxt;
  logic [COL_W+COL_OUT_W-1:0]  col_ext;
  logic [ROW_W+ROW_OUT_W-1:0]  row_ext;
  logic [ADDR_W+LOC_OUT_W-1:0] loc_ext;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid & ~in_stall;
  assign out_free = ~out_valid_r | ~out_stall;
  assign blank    = {attr_r, BLANK_CHAR};
  assign idx_ext  = {{ADDR_W{1'b0}}, in_cell_index};
  assign idx_ok   = (idx_ext < (ADDR_W + IDX_W)'(CELLS));
  assign src_sum  = {1'b0, cnt_r} + (CNT_W + 1)'(COLUMNS);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  tcw_cursor #(
    .COLUMNS   (COLUMNS),
    .ROWS      (ROWS),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cur_ctrl),
    .ch      (ch_r),
    .stat    (cur_stat),
    .loc_r   (cur_loc),
    .col_nxt (cur_col_nxt),
    .row_nxt (cur_row_nxt),
    .loc_nxt (cur_loc_nxt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (kind_r)
          KIND_WRITE: begin
            if (cur_stat.scroll) begin
              state_nxt = ST_SCROLL;
            end else begin
              state_nxt = out_free ? ST_IDLE : ST_EMIT;
            end
          end
          KIND_CLEAR: state_nxt = ST_CLEAR;
          default:    state_nxt = out_free ? ST_IDLE : ST_EMIT;
        endcase
      end
      ST_SCROLL: begin
        if (cnt_r == CNT_W'(CELLS)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_CLEAR: begin
        if (cnt_r == CNT_W'(CELLS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // datapath control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = paddr_r;
    ram_wdata = blank;
    ram_raddr = idx_ext[ADDR_W-1:0];
    cur_ctrl  = '0;
    out_load  = 1'b0;
    cnt_nxt   = cnt_r;
    pend_nxt  = 1'b0;
    paddr_nxt = paddr_r;
    pcopy_nxt = pcopy_r;
    data_nxt  = data_r;
    unique case (state_r)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        ram_wdata = '0;
        cnt_nxt   = (cnt_r == CNT_W'(CELLS - 1)) ? '0 : cnt_r + CNT_W'(1);
      end
      ST_IDLE: begin
        cnt_nxt = '0;
      end
      ST_EXEC: begin
        data_nxt = '0;
        unique case (kind_r)
          KIND_WRITE: begin
            cur_ctrl.apply = 1'b1;
            if (cur_stat.print) begin
              ram_we    = 1'b1;
              ram_waddr = cur_loc;
              ram_wdata = {attr_r, ch_r};
            end
            out_load = out_free & ~cur_stat.scroll;
          end
          KIND_CLEAR: begin
            cur_ctrl.home = 1'b1;
          end
          KIND_READ: begin
            data_nxt = inrange_r ? ram_rdata : '0;
            out_load = out_free;
          end
          default: begin
            out_load = out_free;
          end
        endcase
      end
      ST_SCROLL: begin
        // read one row ahead, write back in the next cycle from the registered read data
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = paddr_r;
          ram_wdata = pcopy_r ? ram_rdata : blank;
        end
        if (cnt_r < CNT_W'(CELLS)) begin
          ram_raddr = src_sum[ADDR_W-1:0];
          pend_nxt  = 1'b1;
          paddr_nxt = cnt_r[ADDR_W-1:0];
          pcopy_nxt = (cnt_r < CNT_W'(COPY_LEN));
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_r[ADDR_W-1:0];
        ram_wdata = blank;
        cnt_nxt   = (cnt_r == CNT_W'(CELLS - 1)) ? '0 : cnt_r + CNT_W'(1);
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  assign col_ext = {{COL_OUT_W{1'b0}}, cur_col_nxt};
  assign row_ext = {{ROW_OUT_W{1'b0}}, cur_row_nxt};
  assign loc_ext = {{LOC_OUT_W{1'b0}}, cur_loc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      attr_r      <= ATTR_RESET;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    paddr_r <= paddr_nxt;
    pcopy_r <= pcopy_nxt;
    data_r  <= data_nxt;
    if (in_acc) begin
      kind_r    <= kind_t'(in_kind);
      ch_r      <= in_character;
      inrange_r <= idx_ok;
    end
    if (out_load) begin
      out_col_r  <= col_ext[COL_OUT_W-1:0];
      out_row_r  <= row_ext[ROW_OUT_W-1:0];
      out_loc_r  <= loc_ext[LOC_OUT_W-1:0];
      out_data_r <= data_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_col_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_pos = out_loc_r;
  assign out_cell_data  = out_data_r;

  `TCW_CHECK(a_no_write_idle, ram_we |-> state_r != ST_IDLE, "RAM write while idle")
  `TCW_CHECK_NEXT(a_accept_exec, in_acc, state_r == ST_EXEC, "accepted transaction not executed")
  `TCW_CHECK(a_load_free, out_load |-> out_free, "result overwrites a pending transaction")
  `TCW_CHECK(a_scroll_addr, pend_r |-> int'(paddr_r) < CELLS, "scroll write out of range")

endmodule
